// File: hw/rtl/pkn_pkg.sv
// Package for the pose keypoint normalizer: sizes, fixed point types and
// the controller to datapath command and status structs. No dependencies.
package pkn_pkg;
	localparam int NUM_POINTS = 33;
	localparam int CNT_W = $clog2(NUM_POINTS + 1);
	localparam int ADDR_W = $clog2(NUM_POINTS);
	localparam int HIP_A = 23;
	localparam int HIP_B = 24;
	localparam int SHOULDER_A = 11;
	localparam int SHOULDER_B = 12;
	localparam int SQRT_STEPS = 21;
	localparam int DIV_STEPS = 32;
	localparam int STEP_W = $clog2(DIV_STEPS);
	localparam int PADDR_W = 1;
	localparam logic [PADDR_W-1:0] REG_MIN_SCALE = 1'b0;
	localparam logic [20:0] SCALE_ONE = 21'd65536;

	typedef logic signed [15:0] coord_t;
	typedef logic [12:0] vis_t;

	typedef struct packed {
		logic store;
		logic square;
		logic sqrt_init;
		logic sqrt_step;
		logic scale_fix;
		logic rd;
		logic div_init;
		logic div_step;
		logic out_load;
		logic out_zero;
		logic out_last;
	} pkn_cmd_t;

	typedef struct packed {
		logic step_done;
	} pkn_status_t;
endpackage

// File: hw/rtl/pkn_point_if.sv
// Input channel carrying one keypoint transfer.
// Depends on pkn_pkg.
interface pkn_point_if import pkn_pkg::*; ();
	logic valid;
	logic ready;
	logic point_valid;
	coord_t point_x;
	coord_t point_y;
	coord_t point_z;
	vis_t point_visibility;
	logic frame_end;

	modport source(output valid, point_valid, point_x, point_y, point_z,
		point_visibility, frame_end, input ready);
	modport sink(input valid, point_valid, point_x, point_y, point_z,
		point_visibility, frame_end, output ready);
endinterface

// File: hw/rtl/pkn_feat_if.sv
// Output channel carrying one normalized keypoint transfer.
// Depends on pkn_pkg.
interface pkn_feat_if import pkn_pkg::*; ();
	logic valid;
	logic ready;
	coord_t norm_x;
	coord_t norm_y;
	coord_t norm_z;
	vis_t vis_out;
	logic last_feature;

	modport source(output valid, norm_x, norm_y, norm_z, vis_out, last_feature,
		input ready);
	modport sink(input valid, norm_x, norm_y, norm_z, vis_out, last_feature,
		output ready);
endinterface

// File: hw/rtl/pkn_datapath.sv
// Datapath: keypoint memory, shoulder and hip registers, bit serial square
// root and three shared-divisor serial dividers. Depends on pkn_pkg.
module pkn_datapath import pkn_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  pkn_cmd_t          cmd,
	output pkn_status_t       status,
	input  logic [ADDR_W-1:0] addr,
	input  coord_t            in_x,
	input  coord_t            in_y,
	input  coord_t            in_z,
	input  vis_t              in_vis,
	input  logic [12:0]       min_scale,
	output coord_t            norm_x,
	output coord_t            norm_y,
	output coord_t            norm_z,
	output vis_t              vis_out,
	output logic              last_feature
);
	logic [60:0] mem_q [NUM_POINTS];
	logic [60:0] rd_s1;
	coord_t sax_q, say_q, sbx_q, sby_q, hax_q, hay_q, hbx_q, hby_q;
	logic [32:0] dxx_q, dyy_q;
	logic [41:0] rad_q;
	logic [22:0] srem_q;
	logic [20:0] root_q;
	logic [20:0] scale_q;
	logic [STEP_W-1:0] step_q;
	logic [31:0] dvd_q [3];
	logic [22:0] drem_q [3];
	logic neg_q [3];
	coord_t sat [3];

	logic signed [16:0] dx, dy, sx, sy;
	logic signed [33:0] px, py;
	logic [33:0] d2;
	logic [22:0] sr, st;
	logic signed [17:0] num [3];
	logic [17:0] mag [3];
	logic [21:0] divisor;
	logic [22:0] dr [3];

	assign dx = 17'(sax_q) - 17'(sbx_q);
	assign dy = 17'(say_q) - 17'(sby_q);
	assign px = dx * dx;
	assign py = dy * dy;
	assign d2 = 34'(dxx_q) + 34'(dyy_q);
	assign sx = 17'(hax_q) + 17'(hbx_q);
	assign sy = 17'(hay_q) + 17'(hby_q);
	assign sr = {srem_q[20:0], rad_q[41:40]};
	assign st = {root_q, 2'b01};
	assign divisor = {scale_q, 1'b0};
	assign status.step_done = (step_q == '0);

	always_comb begin
		num[0] = {rd_s1[60], rd_s1[60:45], 1'b0} - 18'(sx);
		num[1] = {rd_s1[44], rd_s1[44:29], 1'b0} - 18'(sy);
		num[2] = {rd_s1[28], rd_s1[28:13], 1'b0};
		for (int i = 0; i < 3; i++) begin
			mag[i] = num[i][17] ? 18'(-num[i]) : 18'(num[i]);
			dr[i] = {drem_q[i][21:0], dvd_q[i][31]};
			if (neg_q[i]) begin
				sat[i] = (dvd_q[i] > 32'd32768) ? 16'sh8000 : coord_t'(-dvd_q[i][15:0]);
			end else begin
				sat[i] = (dvd_q[i] > 32'd32767) ? 16'sh7fff : coord_t'(dvd_q[i][15:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			mem_q[addr] <= {in_x, in_y, in_z, in_vis};
			if (addr == ADDR_W'(SHOULDER_A)) begin
				sax_q <= in_x;
				say_q <= in_y;
			end
			if (addr == ADDR_W'(SHOULDER_B)) begin
				sbx_q <= in_x;
				sby_q <= in_y;
			end
			if (addr == ADDR_W'(HIP_A)) begin
				hax_q <= in_x;
				hay_q <= in_y;
			end
			if (addr == ADDR_W'(HIP_B)) begin
				hbx_q <= in_x;
				hby_q <= in_y;
			end
		end
		if (cmd.rd) begin
			rd_s1 <= mem_q[addr];
		end
		if (cmd.square) begin
			dxx_q <= px[32:0];
			dyy_q <= py[32:0];
		end
		if (cmd.sqrt_init) begin
			rad_q <= {d2, 8'b0};
			srem_q <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q <= {rad_q[39:0], 2'b00};
			if (sr >= st) begin
				srem_q <= sr - st;
				root_q <= {root_q[19:0], 1'b1};
			end else begin
				srem_q <= sr;
				root_q <= {root_q[19:0], 1'b0};
			end
		end
		if (cmd.scale_fix) begin
			if (root_q == '0 || root_q < 21'({min_scale, 4'b0})) begin
				scale_q <= SCALE_ONE;
			end else begin
				scale_q <= root_q;
			end
		end
		for (int i = 0; i < 3; i++) begin
			if (cmd.div_init) begin
				dvd_q[i] <= {mag[i], 14'b0} + 32'(scale_q);
				drem_q[i] <= '0;
				neg_q[i] <= num[i][17];
			end else if (cmd.div_step) begin
				if (dr[i] >= 23'(divisor)) begin
					drem_q[i] <= dr[i] - 23'(divisor);
					dvd_q[i] <= {dvd_q[i][30:0], 1'b1};
				end else begin
					drem_q[i] <= dr[i];
					dvd_q[i] <= {dvd_q[i][30:0], 1'b0};
				end
			end
		end
		if (cmd.out_load) begin
			norm_x <= sat[0];
			norm_y <= sat[1];
			norm_z <= sat[2];
			vis_out <= rd_s1[12:0];
			last_feature <= cmd.out_last;
		end else if (cmd.out_zero) begin
			norm_x <= '0;
			norm_y <= '0;
			norm_z <= '0;
			vis_out <= '0;
			last_feature <= cmd.out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.sqrt_init) begin
			step_q <= STEP_W'(SQRT_STEPS - 1);
		end else if (cmd.div_init) begin
			step_q <= STEP_W'(DIV_STEPS - 1);
		end else if ((cmd.sqrt_step || cmd.div_step) && step_q != '0) begin
			step_q <= step_q - 1'b1;
		end
	end
endmodule

// File: hw/rtl/pkn_ctrl.sv
// Controller: frame collection, scale computation sequence and result
// emission. Depends on pkn_pkg.
module pkn_ctrl import pkn_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              point_valid,
	input  logic              frame_end,
	input  logic              out_ready,
	output logic              out_valid,
	output pkn_cmd_t          cmd,
	input  pkn_status_t       status,
	output logic [ADDR_W-1:0] addr
);
	typedef enum logic [3:0] {
		S_IDLE, S_ZERO, S_SQUARE, S_ROOT_INIT, S_ROOT, S_FIX, S_READ, S_DIV_INIT,
		S_DIV, S_EMIT
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] count_q;
	logic [ADDR_W-1:0] idx_q;
	logic out_valid_q;
	logic take, room, out_free, full, idx_last;

	assign take = in_valid && in_ready;
	assign room = count_q < CNT_W'(NUM_POINTS);
	assign full = (count_q == CNT_W'(NUM_POINTS))
		|| (point_valid && count_q == CNT_W'(NUM_POINTS - 1));
	assign out_free = !out_valid_q || out_ready;
	assign idx_last = idx_q == ADDR_W'(NUM_POINTS - 1);
	assign in_ready = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign addr = (state_q == S_IDLE) ? count_q[ADDR_W-1:0] : idx_q;

	always_comb begin
		cmd = '0;
		cmd.out_last = idx_last;
		case (state_q)
			S_IDLE: cmd.store = take && point_valid && room;
			S_ZERO: cmd.out_zero = out_free;
			S_SQUARE: cmd.square = 1'b1;
			S_ROOT_INIT: cmd.sqrt_init = 1'b1;
			S_ROOT: cmd.sqrt_step = 1'b1;
			S_FIX: cmd.scale_fix = 1'b1;
			S_READ: cmd.rd = 1'b1;
			S_DIV_INIT: cmd.div_init = 1'b1;
			S_DIV: cmd.div_step = 1'b1;
			S_EMIT: cmd.out_load = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load || cmd.out_zero) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						if (frame_end) begin
							count_q <= '0;
							idx_q <= '0;
							state_q <= full ? S_SQUARE : S_ZERO;
						end else if (point_valid && room) begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				S_ZERO: begin
					if (out_free) begin
						if (idx_last) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_SQUARE: state_q <= S_ROOT_INIT;
				S_ROOT_INIT: state_q <= S_ROOT;
				S_ROOT: begin
					if (status.step_done) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: state_q <= S_READ;
				S_READ: state_q <= S_DIV_INIT;
				S_DIV_INIT: state_q <= S_DIV;
				S_DIV: begin
					if (status.step_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						if (idx_last) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= S_READ;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: hw/rtl/pose_keypoint_normalizer_unit.sv
// Top level of the pose keypoint normalizer: APB register, controller and
// datapath. Depends on pkn_pkg, pkn_point_if, pkn_feat_if, pkn_ctrl, pkn_datapath.
// Keypoints are taken one per cycle while collecting a frame. A transfer with
// frame_end starts emission of 33 results; no input is taken until the last
// result has been loaded into the output register. A complete frame goes
// through the square, square root init, bit serial square root and scale fix
// steps, then a read, divider init, serial division and output load per
// result; an incomplete frame gives 33 zero results at one per cycle while
// the output is not stalled; output stalls hold both sequences.
module pose_keypoint_normalizer_unit import pkn_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	pkn_point_if.sink          points,
	pkn_feat_if.source         features,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	logic [12:0] min_scale_q;
	pkn_cmd_t cmd;
	pkn_status_t status;
	logic [ADDR_W-1:0] addr;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_MIN_SCALE) ? {19'b0, min_scale_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_scale_q <= 13'd4;
		end else if (psel && penable && pwrite && paddr == REG_MIN_SCALE) begin
			min_scale_q <= pwdata[12:0];
		end
	end

	pkn_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(points.valid),
		.in_ready(points.ready),
		.point_valid(points.point_valid),
		.frame_end(points.frame_end),
		.out_ready(features.ready),
		.out_valid(features.valid),
		.cmd(cmd),
		.status(status),
		.addr(addr)
	);

	pkn_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.addr(addr),
		.in_x(points.point_x),
		.in_y(points.point_y),
		.in_z(points.point_z),
		.in_vis(points.point_visibility),
		.min_scale(min_scale_q),
		.norm_x(features.norm_x),
		.norm_y(features.norm_y),
		.norm_z(features.norm_z),
		.vis_out(features.vis_out),
		.last_feature(features.last_feature)
	);
endmodule

// File: tb/pkn_checker.sv
`timescale 1ns / 100ps
// Checker for the pose keypoint normalizer: watches the keypoint, feature and
// register ports, predicts every feature transfer and compares it.
// Depends on pkn_pkg, pkn_point_if and pkn_feat_if.
module pkn_checker import pkn_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	pkn_point_if               points,
	pkn_feat_if                features,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	output int                 errors,
	output int                 pending,
	output int                 results_seen,
	output int                 frames_closed
);
	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		vis_t   vis;
		logic   last;
	} feature_t;

	coord_t      kp_x [NUM_POINTS];
	coord_t      kp_y [NUM_POINTS];
	coord_t      kp_z [NUM_POINTS];
	vis_t        kp_vis [NUM_POINTS];
	int          kp_count;
	logic [12:0] min_scale;
	feature_t    feature_queue [$];

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic coord_t divide_round(input longint n, input longint unsigned s);
		longint unsigned mag;
		longint unsigned q;
		mag = (n < 0) ? longint'(-n) : longint'(n);
		q = ((mag << 14) + s) / (2 * s);
		if (n < 0) begin
			if (q > 32768)
				q = 32768;
			return coord_t'(-longint'(q));
		end
		if (q > 32767)
			q = 32767;
		return coord_t'(q);
	endfunction

	task automatic emit_frame();
		feature_t f;
		longint sum_x;
		longint sum_y;
		longint dx;
		longint dy;
		longint unsigned scale;
		for (int i = 0; i < NUM_POINTS; i++) begin
			f = '0;
			f.last = (i == NUM_POINTS - 1);
			feature_queue.insert(feature_queue.size(), f);
		end
		if (kp_count < NUM_POINTS) begin
			kp_count = 0;
			return;
		end
		sum_x = longint'(kp_x[HIP_A]) + longint'(kp_x[HIP_B]);
		sum_y = longint'(kp_y[HIP_A]) + longint'(kp_y[HIP_B]);
		dx = longint'(kp_x[SHOULDER_A]) - longint'(kp_x[SHOULDER_B]);
		dy = longint'(kp_y[SHOULDER_A]) - longint'(kp_y[SHOULDER_B]);
		scale = int_sqrt(longint'(dx * dx + dy * dy) << 8);
		if (scale == 0 || scale < (longint'(min_scale) << 4))
			scale = 65536;
		for (int i = 0; i < NUM_POINTS; i++) begin
			f.x = divide_round(2 * longint'(kp_x[i]) - sum_x, scale);
			f.y = divide_round(2 * longint'(kp_y[i]) - sum_y, scale);
			f.z = divide_round(2 * longint'(kp_z[i]), scale);
			f.vis = kp_vis[i];
			f.last = (i == NUM_POINTS - 1);
			feature_queue[feature_queue.size() - NUM_POINTS + i] = f;
		end
		kp_count = 0;
	endtask

	task automatic report(input string what, input int got, input int want);
		errors++;
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		feature_t w;
		if (!arst_n) begin
			kp_count = 0;
			min_scale = 13'd4;
			feature_queue.delete();
			errors = 0;
			results_seen = 0;
			frames_closed = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == REG_MIN_SCALE)
				min_scale = pwdata[12:0];
			if (features.valid && features.ready) begin
				results_seen++;
				if (feature_queue.size() == 0) begin
					report("unexpected transfer", 1, 0);
				end else begin
					w = feature_queue.pop_front();
					if (features.norm_x !== w.x)
						report("norm_x", features.norm_x, w.x);
					if (features.norm_y !== w.y)
						report("norm_y", features.norm_y, w.y);
					if (features.norm_z !== w.z)
						report("norm_z", features.norm_z, w.z);
					if (features.vis_out !== w.vis)
						report("vis_out", features.vis_out, w.vis);
					if (features.last_feature !== w.last)
						report("last_feature", features.last_feature, w.last);
				end
			end
			if (points.valid && points.ready) begin
				if (points.point_valid && kp_count < NUM_POINTS) begin
					kp_x[kp_count] = points.point_x;
					kp_y[kp_count] = points.point_y;
					kp_z[kp_count] = points.point_z;
					kp_vis[kp_count] = points.point_visibility;
					kp_count++;
				end
				if (points.frame_end) begin
					frames_closed++;
					emit_frame();
				end
			end
		end
		pending = feature_queue.size();
	end
endmodule

// File: tb/pose_keypoint_normalizer_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for pose_keypoint_normalizer_unit: drives keypoint frames and
// register writes under varied flow control. Depends on pkn_pkg, the two
// channel interfaces, pkn_checker and the block itself.
module pose_keypoint_normalizer_unit_tb import pkn_pkg::*; ();
	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE_CYCLES = 60;
	localparam int PHASES = 6;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	int                 errors;
	int                 pending;
	int                 results_seen;
	int                 frames_closed;
	int                 cycles;
	int                 items_sent;
	int                 send_idle;
	int                 recv_stall;

	pkn_point_if points ();
	pkn_feat_if  features ();

	pose_keypoint_normalizer_unit dut (
		.clk(clk), .arst_n(arst_n), .points(points), .features(features),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	pkn_checker checker_i (
		.clk(clk), .arst_n(arst_n), .points(points), .features(features),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending),
		.results_seen(results_seen), .frames_closed(frames_closed)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			features.ready <= 1'b0;
		end else begin
			features.ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	function automatic coord_t pick_coord();
		case ($urandom_range(7))
			0: return coord_t'(-32768);
			1: return coord_t'(32767);
			2: return coord_t'($urandom_range(600)) - coord_t'(300);
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic vis_t pick_vis();
		case ($urandom_range(3))
			0: return vis_t'(4096);
			1: return vis_t'($urandom);
			default: return vis_t'($urandom_range(4096));
		endcase
	endfunction

	task automatic send(input logic pv, input coord_t x, input coord_t y, input coord_t z,
			input vis_t v, input logic fe);
		if (send_idle > 0 && $urandom_range(99) < send_idle) begin
			points.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		points.valid <= 1'b1;
		points.point_valid <= pv;
		points.point_x <= x;
		points.point_y <= y;
		points.point_z <= z;
		points.point_visibility <= v;
		points.frame_end <= fe;
		@(posedge clk);
		while (!points.ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_frame(input int count, input bit close_empty);
		coord_t xs [64];
		coord_t ys [64];
		bit     marked;
		for (int i = 0; i < count; i++) begin
			xs[i] = pick_coord();
			ys[i] = pick_coord();
		end
		if ($urandom_range(3) == 0) begin
			xs[SHOULDER_B] = xs[SHOULDER_A] + coord_t'($urandom_range(8)) - coord_t'(4);
			ys[SHOULDER_B] = ys[SHOULDER_A] + coord_t'($urandom_range(8)) - coord_t'(4);
		end
		for (int i = 0; i < count; i++) begin
			marked = (i == count - 1) && !close_empty;
			send(1'b1, xs[i], ys[i], pick_coord(), pick_vis(), marked);
		end
		if (close_empty || count == 0)
			send(1'b0, pick_coord(), pick_coord(), pick_coord(), pick_vis(), 1'b1);
	endtask

	task automatic write_min_scale(input logic [12:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_MIN_SCALE;
		pwdata <= {19'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain();
		points.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int          start;
		int          pick;
		logic [12:0] settings [PHASES];
		settings = '{13'd0, 13'd4096, 13'd8191, 13'd64, 13'd4, 13'd0};
		settings[5] = 13'($urandom_range(4096));
		cycles = 0;
		items_sent = 0;
		send_idle = 0;
		recv_stall = 0;
		arst_n = 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		points.valid <= 1'b0;
		points.point_valid <= 1'b0;
		points.point_x <= '0;
		points.point_y <= '0;
		points.point_z <= '0;
		points.point_visibility <= '0;
		points.frame_end <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(1'b0, 16'sd0, 16'sd0, 16'sd0, 13'd0, 1'b1);
		send(1'b0, coord_t'(-32768), 16'sd32767, 16'sd0, 13'd8191, 1'b0);
		send(1'b1, coord_t'(-32768), coord_t'(-32768), coord_t'(-32768), 13'd0, 1'b0);
		send(1'b1, 16'sd32767, 16'sd32767, 16'sd32767, 13'd8191, 1'b0);
		send(1'b1, 16'sd0, 16'sd0, 16'sd0, 13'd4096, 1'b1);
		send_frame(5, 1'b1);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			write_min_scale(settings[ph]);
			send_idle = (ph % 4 == 1) ? 66 : (ph % 4 == 3) ? 38 : 0;
			recv_stall = (ph % 4 == 2) ? 66 : (ph % 4 == 3) ? 38 : 0;
			start = items_sent;
			while (items_sent - start < 60) begin
				pick = $urandom_range(99);
				if (pick < 65)
					send_frame(NUM_POINTS, $urandom_range(4) == 0);
				else if (pick < 75)
					send_frame($urandom_range(NUM_POINTS + 1, NUM_POINTS + 5), 1'b0);
				else if (pick < 85)
					send_frame($urandom_range(1, NUM_POINTS - 1), $urandom_range(1));
				else if (pick < 93)
					send_frame(0, 1'b1);
				else
					send(1'b0, pick_coord(), pick_coord(), pick_coord(), pick_vis(), 1'b0);
				if (ph == 2 && items_sent - start >= 30 && items_sent - start < 55) begin
					points.valid <= 1'b0;
					@(posedge clk);
					while (pending != 0)
						@(posedge clk);
				end
			end
			drain();
		end

		$display("Covered %0d keypoint transfers, %0d frames and %0d feature transfers",
			items_sent, frames_closed, results_seen);
		$display("over %0d min_scale settings and four flow control mixes", PHASES);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

// File: sim.f
hw/rtl/pkn_pkg.sv
hw/rtl/pkn_point_if.sv
hw/rtl/pkn_feat_if.sv
hw/rtl/pkn_datapath.sv
hw/rtl/pkn_ctrl.sv
hw/rtl/pose_keypoint_normalizer_unit.sv
tb/pkn_checker.sv
tb/pose_keypoint_normalizer_unit_tb.sv
